[hw/rtl/ppou_pkg.sv]
// shared types, constants and register codes of the pixel point operation unit
`timescale 1ns / 1ps
package ppou_pkg;

	localparam int PIXEL_BITS     = 8;
	localparam int GAIN_FRAC_BITS = 12;
	localparam int GAIN_BITS      = 16;
	localparam int THR_BITS       = PIXEL_BITS + 1;
	localparam int NUM_BITS       = 2 * PIXEL_BITS;
	localparam int PROD_BITS      = PIXEL_BITS + GAIN_BITS;
	localparam int WHOLE_BITS     = PIXEL_BITS + GAIN_FRAC_BITS;
	localparam int DIV_STAGES     = PIXEL_BITS;
	localparam int TABLE_DEPTH    = 1 << PIXEL_BITS;
	localparam int REG_IDX_BITS   = 3;
	localparam int REG_DATA_BITS  = GAIN_BITS;
	localparam int IN_DATA_BITS   = 3 * PIXEL_BITS;

	localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};

	typedef enum logic [2:0] {
		MODE_TABLE     = 3'd0,
		MODE_NEGATIVE  = 3'd1,
		MODE_DIM       = 3'd2,
		MODE_BRIGHTEN  = 3'd3,
		MODE_STRETCH   = 3'd4,
		MODE_COMPRESS  = 3'd5,
		MODE_THRESHOLD = 3'd6
	} mode_t;

	localparam logic [REG_IDX_BITS-1:0] REG_MODE         = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_GAIN         = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_STRETCH_LOW  = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_STRETCH_HIGH = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_OUT_LOW      = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_OUT_HIGH     = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD    = 3'd6;

	typedef struct packed {
		mode_t                 mode;
		logic [GAIN_BITS-1:0]  gain;
		logic [PIXEL_BITS-1:0] stretch_low;
		logic [PIXEL_BITS-1:0] stretch_high;
		logic [PIXEL_BITS-1:0] out_low;
		logic [PIXEL_BITS-1:0] out_high;
		logic [THR_BITS-1:0]   threshold_level;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		mode:            MODE_NEGATIVE,
		gain:            '0,
		stretch_low:     '0,
		stretch_high:    PIX_MAX,
		out_low:         '0,
		out_high:        PIX_MAX,
		threshold_level: THR_BITS'(1 << (PIXEL_BITS - 1))
	};

	typedef struct packed {
		logic [NUM_BITS-1:0]   rem;
		logic [PIXEL_BITS-1:0] den;
		logic [PIXEL_BITS-1:0] quo;
		logic [PIXEL_BITS-1:0] res;
		logic                  use_div;
		logic                  comp;
		logic                  neg;
		logic                  last;
	} div_item_t;

endpackage

[hw/rtl/ppou_ram.sv]
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module ppou_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/ppou_front.sv]
// input stages: table access, multiplies and per-mode result selection
`timescale 1ns / 1ps
module ppou_front import ppou_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [IN_DATA_BITS-1:0] s_tdata,
	input  logic                    s_tlast,
	input  logic                    s_tuser,
	output logic                    valid_out,
	output div_item_t               item_out,
	input  logic                    ready_in
);

	logic                  valid_s1, valid_s2, valid_s3;
	logic                  ready_s1, ready_s2, ready_s3;
	logic [PIXEL_BITS-1:0] pix_s1, pix_s2, tbl_s2;
	logic                  last_s1, last_s2;
	logic [PROD_BITS-1:0]  prod_s2;
	logic [NUM_BITS-1:0]   num_s2;
	logic [PIXEL_BITS-1:0] den_s2;
	logic                  neg_s2;
	div_item_t             item_s3;

	logic [PIXEL_BITS-1:0] pixel_in, entry_index, entry_value, tbl_rd;
	logic                  accept;

	logic [PIXEL_BITS-1:0] lo_diff, mag;
	logic [NUM_BITS-1:0]   num_d;
	logic [PIXEL_BITS-1:0] den_d;

	logic [WHOLE_BITS-1:0] whole;
	logic [PROD_BITS-1:0]  dim_d;
	logic [PROD_BITS:0]    bright_sum;
	div_item_t             item_d;

	assign pixel_in    = s_tdata[PIXEL_BITS-1:0];
	assign entry_index = s_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
	assign entry_value = s_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS];

	assign ready_s3 = !valid_s3 || ready_in;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;
	assign accept   = s_tvalid && s_tready;

	ppou_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (accept && s_tuser),
		.waddr(entry_index),
		.wdata(entry_value),
		.re   (accept && !s_tuser),
		.raddr(pixel_in),
		.rdata(tbl_rd)
	);

	// stage 1: capture pixel, table read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= accept && !s_tuser;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			pix_s1  <= pixel_in;
			last_s1 <= s_tlast;
		end
	end

	// stage 2: gain product and divider operands
	always_comb begin
		lo_diff = pix_s1 - cfg.stretch_low;
		if (cfg.out_high < cfg.out_low) begin
			mag = cfg.out_low - cfg.out_high;
		end else begin
			mag = cfg.out_high - cfg.out_low;
		end
		if (cfg.mode == MODE_STRETCH) begin
			num_d = {lo_diff, {PIXEL_BITS{1'b0}}} - NUM_BITS'(lo_diff);
			den_d = cfg.stretch_high - cfg.stretch_low;
		end else begin
			num_d = NUM_BITS'(pix_s1 * mag);
			den_d = PIX_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			pix_s2  <= pix_s1;
			last_s2 <= last_s1;
			tbl_s2  <= tbl_rd;
			prod_s2 <= PROD_BITS'(pix_s1 * cfg.gain);
			num_s2  <= num_d;
			den_s2  <= den_d;
			neg_s2  <= cfg.out_high < cfg.out_low;
		end
	end

	// stage 3: per-mode result, or hand-off to the divider
	always_comb begin
		whole      = {pix_s2, {GAIN_FRAC_BITS{1'b0}}};
		dim_d      = PROD_BITS'(whole) - prod_s2;
		bright_sum = (PROD_BITS + 1)'(whole) + (PROD_BITS + 1)'(prod_s2);
		item_d         = '0;
		item_d.rem     = num_s2;
		item_d.den     = den_s2;
		item_d.last    = last_s2;
		item_d.neg     = neg_s2;
		case (cfg.mode)
			MODE_TABLE: begin
				item_d.res = tbl_s2;
			end
			MODE_NEGATIVE: begin
				item_d.res = PIX_MAX - pix_s2;
			end
			MODE_DIM: begin
				if (prod_s2 >= PROD_BITS'(whole)) begin
					item_d.res = '0;
				end else begin
					item_d.res = dim_d[WHOLE_BITS-1:GAIN_FRAC_BITS];
				end
			end
			MODE_BRIGHTEN: begin
				if (bright_sum[PROD_BITS:GAIN_FRAC_BITS] >
						(PROD_BITS - GAIN_FRAC_BITS + 1)'(PIX_MAX)) begin
					item_d.res = PIX_MAX;
				end else begin
					item_d.res = bright_sum[GAIN_FRAC_BITS+PIXEL_BITS-1:GAIN_FRAC_BITS];
				end
			end
			MODE_STRETCH: begin
				if (pix_s2 >= cfg.stretch_high) begin
					item_d.res = PIX_MAX;
				end else if (pix_s2 < cfg.stretch_low) begin
					item_d.res = '0;
				end else begin
					item_d.use_div = 1'b1;
				end
			end
			MODE_COMPRESS: begin
				item_d.use_div = 1'b1;
				item_d.comp    = 1'b1;
			end
			MODE_THRESHOLD: begin
				item_d.res = ({1'b0, pix_s2} >= cfg.threshold_level) ? PIX_MAX : '0;
			end
			default: begin
				item_d.res = pix_s2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			item_s3 <= item_d;
		end
	end

	assign valid_out = valid_s3;
	assign item_out  = item_s3;

endmodule

[hw/rtl/ppou_div.sv]
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module ppou_div import ppou_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output div_item_t out_item
);

	// stages s4 to s11
	logic [DIV_STAGES-1:0] valid_sn;
	logic [DIV_STAGES-1:0] rdy;
	div_item_t             item_sn [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		localparam int SH = DIV_STAGES - 1 - k;

		div_item_t           src;
		div_item_t           nxt;
		logic                src_valid;
		logic                nxt_rdy;
		logic [NUM_BITS-1:0] trial;

		if (k == 0) begin : g_first
			assign src       = in_item;
			assign src_valid = in_valid;
		end else begin : g_chain
			assign src       = item_sn[k-1];
			assign src_valid = valid_sn[k-1];
		end

		if (k == DIV_STAGES - 1) begin : g_tail
			assign nxt_rdy = out_ready;
		end else begin : g_body
			assign nxt_rdy = rdy[k+1];
		end

		assign rdy[k] = !valid_sn[k] || nxt_rdy;
		assign trial  = NUM_BITS'(src.den) << SH;

		always_comb begin
			nxt = src;
			if (src.rem >= trial) begin
				nxt.rem     = src.rem - trial;
				nxt.quo[SH] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[k] <= 1'b0;
			end else if (rdy[k]) begin
				valid_sn[k] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				item_sn[k] <= nxt;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = valid_sn[DIV_STAGES-1];
	assign out_item  = item_sn[DIV_STAGES-1];

endmodule

[hw/rtl/ppou_out.sv]
// output register: final result assembly for direct results and divider modes
`timescale 1ns / 1ps
module ppou_out import ppou_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [PIXEL_BITS-1:0] out_low,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  div_item_t             in_item,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PIXEL_BITS-1:0] m_tdata,
	output logic                  m_tlast
);

	logic                  valid_q;
	logic [PIXEL_BITS-1:0] pix_q;
	logic                  last_q;
	logic [PIXEL_BITS-1:0] pix_d;

	assign in_ready = !valid_q || m_tready;

	always_comb begin
		if (!in_item.use_div) begin
			pix_d = in_item.res;
		end else if (!in_item.comp) begin
			pix_d = in_item.quo;
		end else if (in_item.neg) begin
			pix_d = out_low - in_item.quo;
		end else begin
			pix_d = out_low + in_item.quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			pix_q  <= pix_d;
			last_q <= in_item.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = pix_q;
	assign m_tlast  = last_q;

endmodule

[hw/rtl/pixel_point_operation_unit_top.sv]
// top level of the pixel point operation unit: config registers and stage chain
// a pixel passes stages s1 to s3, the divider stages and the output register before m_tvalid
// throughput: one item per cycle while m_tready does not stall the chain; the twelve-stage
// chain is set by the eight-stage shared divider for stretch and compress
// a table write item gives no result
// reset clears valid bits and restores register defaults; table is undefined until written
`timescale 1ns / 1ps
module pixel_point_operation_unit_top import ppou_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [REG_IDX_BITS-1:0]  cfg_addr,
	input  logic [REG_DATA_BITS-1:0] cfg_wdata,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,  // pixel_in, entry_index, entry_value
	input  logic                     s_tlast,
	input  logic                     s_tuser,  // action
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [PIXEL_BITS-1:0]    m_tdata,  // pixel_out
	output logic                     m_tlast
);

	cfg_t      cfg_q;
	logic      front_valid, front_ready;
	div_item_t front_item;
	logic      div_valid, div_ready;
	div_item_t div_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MODE:         cfg_q.mode            <= mode_t'(cfg_wdata[2:0]);
				REG_GAIN:         cfg_q.gain            <= cfg_wdata[GAIN_BITS-1:0];
				REG_STRETCH_LOW:  cfg_q.stretch_low     <= cfg_wdata[PIXEL_BITS-1:0];
				REG_STRETCH_HIGH: cfg_q.stretch_high    <= cfg_wdata[PIXEL_BITS-1:0];
				REG_OUT_LOW:      cfg_q.out_low         <= cfg_wdata[PIXEL_BITS-1:0];
				REG_OUT_HIGH:     cfg_q.out_high        <= cfg_wdata[PIXEL_BITS-1:0];
				REG_THRESHOLD:    cfg_q.threshold_level <= cfg_wdata[THR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	ppou_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.valid_out(front_valid),
		.item_out (front_item),
		.ready_in (front_ready)
	);

	ppou_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_ready (front_ready),
		.in_item  (front_item),
		.out_valid(div_valid),
		.out_ready(div_ready),
		.out_item (div_item)
	);

	ppou_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.out_low (cfg_q.out_low),
		.in_valid(div_valid),
		.in_ready(div_ready),
		.in_item (div_item),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

[test/tb_pixel_point_operation_unit_top.sv]
// self-checking testbench for the pixel point operation unit: directed rows then random phases
`timescale 1ns / 1ps
module tb_pixel_point_operation_unit_top;
	import ppou_pkg::*;

	localparam logic [2:0] MODE_SPARE  = 3'd7;
	localparam int         SETTLE_CYC  = 16;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         RAND_ITEMS  = 1000;
	localparam int         PHASE_ITEMS = 64;

	typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [2:0]            reg_idx;
		logic [15:0]           reg_val;
		logic                  action;
		logic [PIXEL_BITS-1:0] pix;
		logic                  last;
		logic [PIXEL_BITS-1:0] entry_idx;
		logic [PIXEL_BITS-1:0] entry_val;
		logic                  typed;
		logic [PIXEL_BITS-1:0] typed_pix;
	} dir_row_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pix;
		logic                  last;
	} pix_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [REG_IDX_BITS-1:0]  cfg_addr;
	logic [REG_DATA_BITS-1:0] cfg_wdata;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;
	logic                     s_tlast;
	logic                     s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [PIXEL_BITS-1:0]    m_tdata;
	logic                     m_tlast;

	cfg_t                  shadow_cfg;
	logic [PIXEL_BITS-1:0] lut_shadow [TABLE_DEPTH];
	bit                    lut_known [TABLE_DEPTH];
	int                    lut_known_list [$];
	pix_result_t           pix_expect_q [$];
	dir_row_t              dir_rows [$];
	int                    mismatch_cnt;
	int                    cycle_cnt;
	int                    stall_left;
	bit                    src_quiet;
	bit                    snk_quiet;
	pix_result_t           got_res;
	pix_result_t           want_res;

	pixel_point_operation_unit_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic logic [PIXEL_BITS-1:0] point_xform(input logic [PIXEL_BITS-1:0] p);
		int pv;
		int prod;
		int whole;
		int v;
		pv = int'(p);
		prod = pv * int'(shadow_cfg.gain);
		whole = pv << GAIN_FRAC_BITS;
		case (shadow_cfg.mode)
			MODE_TABLE: v = int'(lut_shadow[p]);
			MODE_NEGATIVE: v = 255 - pv;
			MODE_DIM: v = (prod >= whole) ? 0 : ((whole - prod) >> GAIN_FRAC_BITS);
			MODE_BRIGHTEN: begin
				v = (whole + prod) >> GAIN_FRAC_BITS;
				if (v > 255)
					v = 255;
			end
			MODE_STRETCH: begin
				if (pv >= int'(shadow_cfg.stretch_high))
					v = 255;
				else if (pv < int'(shadow_cfg.stretch_low))
					v = 0;
				else
					v = ((pv - int'(shadow_cfg.stretch_low)) * 255) /
						(int'(shadow_cfg.stretch_high) - int'(shadow_cfg.stretch_low));
			end
			MODE_COMPRESS:
				v = int'(shadow_cfg.out_low) +
					(pv * (int'(shadow_cfg.out_high) - int'(shadow_cfg.out_low))) / 255;
			MODE_THRESHOLD: v = (pv >= int'(shadow_cfg.threshold_level)) ? 255 : 0;
			default: v = pv;
		endcase
		return v[PIXEL_BITS-1:0];
	endfunction

	// mostly short gaps, a few long ones, none while quiet
	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic dir_row_t reg_row(input logic [2:0] idx, input logic [15:0] val);
		dir_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic dir_row_t item_row(input logic act, input logic [7:0] pix,
		input logic lst, input logic [7:0] eidx, input logic [7:0] eval,
		input logic typed, input logic [7:0] typed_pix);
		dir_row_t r;
		r.kind = ROW_ITEM;
		r.reg_idx = '0;
		r.reg_val = '0;
		r.action = act;
		r.pix = pix;
		r.last = lst;
		r.entry_idx = eidx;
		r.entry_val = eval;
		r.typed = typed;
		r.typed_pix = typed_pix;
		return r;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MODE: shadow_cfg.mode = mode_t'(val[2:0]);
			REG_GAIN: shadow_cfg.gain = val;
			REG_STRETCH_LOW: shadow_cfg.stretch_low = val[7:0];
			REG_STRETCH_HIGH: shadow_cfg.stretch_high = val[7:0];
			REG_OUT_LOW: shadow_cfg.out_low = val[7:0];
			REG_OUT_HIGH: shadow_cfg.out_high = val[7:0];
			REG_THRESHOLD: shadow_cfg.threshold_level = val[8:0];
			default: ;
		endcase
	endtask

	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		while (pix_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic push_item(input logic act, input logic [7:0] pix, input logic lst,
		input logic [7:0] eidx, input logic [7:0] eval,
		input logic typed, input logic [7:0] typed_pix);
		int gap;
		pix_result_t res;
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {eval, eidx, pix};
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		if (act) begin
			lut_shadow[eidx] = eval;
			if (!lut_known[eidx]) begin
				lut_known[eidx] = 1'b1;
				lut_known_list.push_back(int'(eidx));
			end
		end else begin
			res.pix = typed ? typed_pix : point_xform(pix);
			res.last = lst;
			pix_expect_q.push_back(res);
		end
		gap = pick_gap(src_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_byte_reg();
		int r;
		logic [15:0] v;
		r = $urandom_range(0, 99);
		v = 16'($urandom_range(0, 255));
		if (r < 20)
			v[7:0] = 8'd0;
		else if (r < 40)
			v[7:0] = 8'd255;
		if ($urandom_range(0, 3) == 0)
			v[15:8] = 8'($urandom);
		return v;
	endfunction

	task automatic run_directed();
		dir_rows = '{
			item_row(1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 8'hFF),
			item_row(1'b0, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1, 8'h00),
			item_row(1'b0, 8'h55, 1'b0, 8'hAA, 8'h33, 1'b0, 8'h00),
			item_row(1'b1, 8'h12, 1'b0, 8'h00, 8'hA5, 1'b0, 8'h00),
			item_row(1'b1, 8'hED, 1'b1, 8'hFF, 8'h5A, 1'b0, 8'h00),
			item_row(1'b1, 8'h00, 1'b0, 8'h81, 8'hFF, 1'b0, 8'h00),
			reg_row(REG_MODE, 16'(MODE_TABLE)),
			item_row(1'b0, 8'h00, 1'b0, 8'hFF, 8'hFF, 1'b1, 8'hA5),
			item_row(1'b0, 8'hFF, 1'b1, 8'h00, 8'h00, 1'b1, 8'h5A),
			item_row(1'b0, 8'h81, 1'b0, 8'h7E, 8'h00, 1'b1, 8'hFF),
			reg_row(REG_MODE, 16'(MODE_THRESHOLD)),
			reg_row(REG_THRESHOLD, 16'd256),
			item_row(1'b0, 8'hFF, 1'b0, 8'h00, 8'h00, 1'b1, 8'h00),
			reg_row(REG_THRESHOLD, 16'd0),
			item_row(1'b0, 8'h00, 1'b1, 8'h00, 8'h00, 1'b1, 8'hFF),
			reg_row(REG_MODE, 16'(MODE_DIM)),
			reg_row(REG_GAIN, 16'hFFFF),
			item_row(1'b0, 8'hFF, 1'b0, 8'h00, 8'h00, 1'b1, 8'h00),
			item_row(1'b0, 8'd200, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00),
			reg_row(REG_MODE, 16'(MODE_BRIGHTEN)),
			item_row(1'b0, 8'hFF, 1'b0, 8'h00, 8'h00, 1'b1, 8'hFF),
			item_row(1'b0, 8'h01, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00),
			reg_row(REG_GAIN, 16'h0000),
			item_row(1'b0, 8'd77, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00),
			reg_row(REG_MODE, 16'(MODE_STRETCH)),
			reg_row(REG_STRETCH_LOW, 16'd200),
			reg_row(REG_STRETCH_HIGH, 16'd100),
			item_row(1'b0, 8'd150, 1'b0, 8'h00, 8'h00, 1'b1, 8'hFF),
			item_row(1'b0, 8'd50, 1'b0, 8'h00, 8'h00, 1'b1, 8'h00),
			reg_row(REG_STRETCH_LOW, 16'd100),
			item_row(1'b0, 8'd99, 1'b0, 8'h00, 8'h00, 1'b1, 8'h00),
			item_row(1'b0, 8'd100, 1'b0, 8'h00, 8'h00, 1'b1, 8'hFF),
			reg_row(REG_MODE, 16'(MODE_COMPRESS)),
			reg_row(REG_OUT_LOW, 16'd200),
			reg_row(REG_OUT_HIGH, 16'd10),
			item_row(1'b0, 8'hFF, 1'b0, 8'h00, 8'h00, 1'b1, 8'd10),
			item_row(1'b0, 8'd100, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00),
			reg_row(REG_MODE, {13'h1FFF, MODE_SPARE}),
			item_row(1'b0, 8'hC3, 1'b0, 8'h00, 8'h00, 1'b1, 8'hC3),
			item_row(1'b0, 8'h3C, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00),
			reg_row(REG_MODE, {13'h1FFF, 3'(MODE_NEGATIVE)}),
			item_row(1'b0, 8'h0F, 1'b0, 8'h00, 8'h00, 1'b1, 8'hF0)
		};
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				drain_pipe();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				push_item(dir_rows[i].action, dir_rows[i].pix, dir_rows[i].last,
					dir_rows[i].entry_idx, dir_rows[i].entry_val,
					dir_rows[i].typed, dir_rows[i].typed_pix);
			end
		end
	endtask

	task automatic load_phase_cfg(input int phase);
		logic [15:0] gain_val;
		logic [8:0]  thr_val;
		int r;
		drain_pipe();
		write_reg(REG_MODE, {13'($urandom_range(0, 1) ? $urandom : 0), 3'(phase % 8)});
		r = $urandom_range(0, 99);
		gain_val = (r < 20) ? 16'h0000 : (r < 40) ? 16'hFFFF : (r < 50) ? 16'h1000 :
			(r < 75) ? 16'($urandom_range(0, 16'h1FFF)) : 16'($urandom);
		write_reg(REG_GAIN, gain_val);
		write_reg(REG_STRETCH_LOW, pick_byte_reg());
		write_reg(REG_STRETCH_HIGH, pick_byte_reg());
		write_reg(REG_OUT_LOW, pick_byte_reg());
		write_reg(REG_OUT_HIGH, pick_byte_reg());
		r = $urandom_range(0, 99);
		thr_val = (r < 15) ? 9'd0 : (r < 30) ? 9'd256 : (r < 40) ? 9'd255 :
			9'($urandom_range(0, 256));
		write_reg(REG_THRESHOLD, {7'($urandom_range(0, 1) ? $urandom : 0), thr_val});
	endtask

	task automatic run_random();
		int sent;
		int phase;
		int r;
		logic [7:0] pix;
		sent = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			load_phase_cfg(phase);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (k == PHASE_ITEMS / 2 && phase % 3 == 1)
					drain_pipe();
				if (r < 15 || (shadow_cfg.mode == MODE_TABLE && lut_known_list.size() == 0)) begin
					push_item(1'b1, 8'($urandom), 1'($urandom_range(0, 9) == 0),
						8'($urandom), 8'($urandom), 1'b0, 8'h00);
				end else begin
					if (shadow_cfg.mode == MODE_TABLE)
						pix = 8'(lut_known_list[$urandom_range(0, lut_known_list.size() - 1)]);
					else if (r < 25)
						pix = 8'd0;
					else if (r < 35)
						pix = 8'd255;
					else if (r < 45)
						pix = shadow_cfg.stretch_low + 8'($urandom_range(0, 2)) - 8'd1;
					else if (r < 55)
						pix = shadow_cfg.stretch_high + 8'($urandom_range(0, 2)) - 8'd1;
					else if (r < 65)
						pix = shadow_cfg.threshold_level[7:0] + 8'($urandom_range(0, 2)) - 8'd1;
					else
						pix = 8'($urandom);
					push_item(1'b0, pix, 1'($urandom_range(0, 9) == 0),
						8'($urandom), 8'($urandom), 1'b0, 8'h00);
				end
				sent++;
				if ($urandom_range(0, 99) == 0)
					src_quiet = ~src_quiet;
			end
			phase++;
		end
	endtask

	// result side: random stalls and compare against the oldest expected item
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_res.pix = m_tdata;
				got_res.last = m_tlast;
				if (pix_expect_q.size() == 0) begin
					$error("unexpected item: pixel_out %0d last_out %0d", got_res.pix, got_res.last);
					mismatch_cnt++;
				end else begin
					want_res = pix_expect_q.pop_front();
					if (got_res.pix !== want_res.pix) begin
						$error("pixel_out expected %0d actual %0d", want_res.pix, got_res.pix);
						mismatch_cnt++;
					end
					if (got_res.last !== want_res.last) begin
						$error("last_out expected %0d actual %0d", want_res.last, got_res.last);
						mismatch_cnt++;
					end
				end
			end
			if ($urandom_range(0, 299) == 0)
				snk_quiet <= ~snk_quiet;
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				m_tready <= 1'b1;
				stall_left <= pick_gap(snk_quiet);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		s_tuser <= 1'b0;
		m_tready <= 1'b0;
		mismatch_cnt = 0;
		cycle_cnt = 0;
		stall_left = 0;
		src_quiet = 1'b0;
		snk_quiet = 1'b0;
		shadow_cfg = CFG_RESET;
		foreach (lut_shadow[i]) begin
			lut_shadow[i] = '0;
			lut_known[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		drain_pipe();
		if (mismatch_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
